// ===== sv/rtmp_chunk_stream_framer_top_macros.svh =====
// Assertion helpers for the chunk stream framer
`ifndef RTMP_CHUNK_STREAM_FRAMER_TOP_MACROS_SVH
`define RTMP_CHUNK_STREAM_FRAMER_TOP_MACROS_SVH

// plain property, sampled on clk, off during reset
`define RCSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication with a fixed delay of cycles
`define RCSF_ASSERT_DLY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> ##dly (cons)) else $error(msg);

`endif

// ===== sv/rcsf_pkg.sv =====
`default_nettype none
package rcsf_pkg;

	typedef enum logic {
		OP_HEADER  = 1'b0,
		OP_PAYLOAD = 1'b1
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [5:0]  chunk_stream_id;
		logic [23:0] time_stamp;
		logic [23:0] message_length;
		logic [7:0]  message_type;
		logic [31:0] message_stream;
		logic [7:0]  payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       error;
	} out_item_t;

	localparam int          HDR_BYTES     = 12;
	localparam int          JOB_CNT_W     = 4;
	localparam int          CHUNK_SIZE_W  = 17;
	localparam logic [16:0] CHUNK_SIZE_RST = 17'd128;
	localparam logic [1:0]  FMT_TYPE3     = 2'b11;

	// bytes of one accepted item, data[0] goes out first
	typedef struct packed {
		logic [HDR_BYTES-1:0][7:0] data;
		logic [JOB_CNT_W-1:0]      cnt;
		logic                      last;
		logic                      err;
	} job_t;

endpackage
`default_nettype wire

// ===== sv/rtmp_chunk_stream_framer_top.sv =====
// channel  | direction | beat contents
// ---------+-----------+------------------------------------------------
// in       | sink      | in_data: op, header fields, payload_byte
// out      | source    | out_data: out_byte, last, error
// cfg      | sink      | cfg_wdata: chunk_size, no handshake back
//
// A header beat gives 12 output beats, a payload beat one, or two when a
// type-3 continuation byte goes first; a stray payload beat gives one error beat.
// Output runs one byte a cycle from the item shift register unless out stalls;
// payload streams at one beat per cycle likewise, if no type-3 byte is due.
// arst_n clears all control state at once. A stalled out side holds the output
// register; in_ready needs an empty item register or an outgoing final byte.
`default_nettype none
module rtmp_chunk_stream_framer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rcsf_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rcsf_pkg::out_item_t out_data,
	input  logic                cfg_wen,
	input  logic [16:0]         cfg_wdata
);

	rcsf_pkg::job_t job;
	logic           accept;

	rcsf_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.accept    (accept),
		.job       (job)
	);

	rcsf_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.job       (job),
		.accept    (accept),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== sv/rcsf_frame.sv =====
`default_nettype none
module rcsf_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [16:0]          cfg_wdata,
	input  rcsf_pkg::in_item_t   in_data,
	input  logic                 accept,
	output rcsf_pkg::job_t       job
);

	logic [16:0] chunk_size_q;
	logic [5:0]  open_id_q;
	logic [23:0] rem_q;
	logic [16:0] bic_q;
	logic        open_q;

	logic [16:0] limit;
	logic        need_cont;
	logic [16:0] bic_base;
	logic [16:0] bic_n;
	logic [23:0] rem_n;
	logic        pay_last;

	assign limit     = (chunk_size_q == '0) ? 17'd1 : chunk_size_q;
	assign need_cont = (bic_q >= limit);
	assign bic_base  = need_cont ? '0 : bic_q;
	assign bic_n     = bic_base + 17'd1;
	assign rem_n     = rem_q - 24'd1;
	assign pay_last  = (rem_n == '0);

	always_comb begin
		job      = '0;
		unique case (in_data.op)
			rcsf_pkg::OP_HEADER: begin
				job.data[0]  = {2'b00, in_data.chunk_stream_id};
				job.data[1]  = in_data.time_stamp[23:16];
				job.data[2]  = in_data.time_stamp[15:8];
				job.data[3]  = in_data.time_stamp[7:0];
				job.data[4]  = in_data.message_length[23:16];
				job.data[5]  = in_data.message_length[15:8];
				job.data[6]  = in_data.message_length[7:0];
				job.data[7]  = in_data.message_type;
				job.data[8]  = in_data.message_stream[7:0];
				job.data[9]  = in_data.message_stream[15:8];
				job.data[10] = in_data.message_stream[23:16];
				job.data[11] = in_data.message_stream[31:24];
				job.cnt      = rcsf_pkg::JOB_CNT_W'(rcsf_pkg::HDR_BYTES);
				job.last     = (in_data.message_length == '0);
			end
			rcsf_pkg::OP_PAYLOAD: begin
				if (!open_q) begin
					job.cnt = 4'd1;
					job.err = 1'b1;
				end else if (need_cont) begin
					job.data[0] = {rcsf_pkg::FMT_TYPE3, open_id_q};
					job.data[1] = in_data.payload_byte;
					job.cnt     = 4'd2;
					job.last    = pay_last;
				end else begin
					job.data[0] = in_data.payload_byte;
					job.cnt     = 4'd1;
					job.last    = pay_last;
				end
			end
			default: job = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= rcsf_pkg::CHUNK_SIZE_RST;
			open_id_q    <= '0;
			rem_q        <= '0;
			bic_q        <= '0;
			open_q       <= 1'b0;
		end else begin
			if (cfg_wen) begin
				chunk_size_q <= cfg_wdata;
			end
			if (accept) begin
				if (in_data.op == rcsf_pkg::OP_HEADER) begin
					open_id_q <= in_data.chunk_stream_id;
					rem_q     <= in_data.message_length;
					bic_q     <= '0;
					open_q    <= (in_data.message_length != '0);
				end else if (open_q) begin
					rem_q  <= rem_n;
					bic_q  <= pay_last ? '0 : bic_n;
					open_q <= !pay_last;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/rcsf_serial.sv =====
`default_nettype none
module rcsf_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rcsf_pkg::job_t      job,
	output logic                accept,
	output logic                out_valid,
	input  logic                out_ready,
	output rcsf_pkg::out_item_t out_data
);

	logic [rcsf_pkg::HDR_BYTES-1:0][7:0] data_s1;
	logic [rcsf_pkg::JOB_CNT_W-1:0]      cnt_s1;
	logic                                last_s1;
	logic                                err_s1;

	logic                out_valid_q;
	rcsf_pkg::out_item_t out_data_q;

	logic adv;
	logic final_beat;

	assign adv        = (cnt_s1 != '0) && (!out_valid_q || out_ready);
	assign final_beat = (cnt_s1 == 4'd1);
	assign in_ready   = (cnt_s1 == '0) || (final_beat && adv);
	assign accept     = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_s1 <= job.cnt;
			end else if (adv) begin
				cnt_s1 <= cnt_s1 - 4'd1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= job.data;
			last_s1 <= job.last;
			err_s1  <= job.err;
		end else if (adv) begin
			data_s1 <= {8'h00, data_s1[rcsf_pkg::HDR_BYTES-1:1]};
		end
		if (adv) begin
			out_data_q.out_byte <= data_s1[0];
			out_data_q.last     <= last_s1 && final_beat;
			out_data_q.error    <= err_s1 && final_beat;
		end
	end

endmodule
`default_nettype wire

// ===== sv/rcsf_checker.sv =====
`default_nettype none
`include "rtmp_chunk_stream_framer_top_macros.svh"
module rcsf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input rcsf_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input rcsf_pkg::out_item_t out_data
);

	// stalled beat holds
	`RCSF_ASSERT_DLY(a_out_hold, out_valid && !out_ready, 1, out_valid && $stable(out_data), "out beat changed while stalled")

	// error beats never close a message
	`RCSF_ASSERT(a_err_not_last, !(out_valid && out_data.error && out_data.last), "error beat flagged last")

	// header expands to several beats, so no new item next cycle
	`RCSF_ASSERT_DLY(a_hdr_busy, in_valid && in_ready && (in_data.op == rcsf_pkg::OP_HEADER), 1, !in_ready, "ready straight after header beat")

	// every accepted item is followed by out_valid high, from its own beat or a stalled one
	`RCSF_ASSERT_DLY(a_item_out, in_valid && in_ready, 2, out_valid, "accepted item produced no output")

endmodule

bind rtmp_chunk_stream_framer_top rcsf_checker u_rcsf_checker (.*);
`default_nettype wire

// ===== tb/sv/rcsf_stream_checker.sv =====
`default_nettype none
module rcsf_stream_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  rcsf_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  rcsf_pkg::out_item_t out_data,
	input  logic                cfg_wen,
	input  logic [16:0]         cfg_wdata,
	output int                  mismatches,
	output int                  owed
);

	logic [16:0]         chunk_size;
	logic [5:0]          open_csid;
	logic [23:0]         remaining;
	logic [16:0]         in_chunk;
	logic                msg_open;
	rcsf_pkg::out_item_t want_bytes[$];
	rcsf_pkg::out_item_t want;
	int                  bad;

	function automatic rcsf_pkg::out_item_t beat(input logic [7:0] b, input logic l,
			input logic e);
		rcsf_pkg::out_item_t r;
		r.out_byte = b;
		r.last     = l;
		r.error    = e;
		return r;
	endfunction

	// append one beat to the expected stream
	function automatic void expect_beat(input logic [7:0] b, input logic l, input logic e);
		want_bytes.insert(want_bytes.size(), beat(b, l, e));
	endfunction

	// expected chunk stream bytes for one accepted input beat
	function automatic void frame_item(input rcsf_pkg::in_item_t it);
		logic [7:0]  hdr [rcsf_pkg::HDR_BYTES];
		logic [16:0] limit;
		int          i;
		if (it.op == rcsf_pkg::OP_HEADER) begin
			hdr[0]  = {2'b00, it.chunk_stream_id};
			hdr[1]  = it.time_stamp[23:16];
			hdr[2]  = it.time_stamp[15:8];
			hdr[3]  = it.time_stamp[7:0];
			hdr[4]  = it.message_length[23:16];
			hdr[5]  = it.message_length[15:8];
			hdr[6]  = it.message_length[7:0];
			hdr[7]  = it.message_type;
			hdr[8]  = it.message_stream[7:0];
			hdr[9]  = it.message_stream[15:8];
			hdr[10] = it.message_stream[23:16];
			hdr[11] = it.message_stream[31:24];
			for (i = 0; i < rcsf_pkg::HDR_BYTES; i++)
				expect_beat(hdr[i],
					(i == rcsf_pkg::HDR_BYTES - 1) && (it.message_length == 24'd0), 1'b0);
			open_csid = it.chunk_stream_id;
			remaining = it.message_length;
			in_chunk  = '0;
			msg_open  = (it.message_length != 24'd0);
		end else if (!msg_open) begin
			expect_beat(8'h00, 1'b0, 1'b1);
		end else begin
			limit = (chunk_size == '0) ? 17'd1 : chunk_size;
			if (in_chunk >= limit) begin
				expect_beat({rcsf_pkg::FMT_TYPE3, open_csid}, 1'b0, 1'b0);
				in_chunk = '0;
			end
			remaining = remaining - 24'd1;
			in_chunk  = in_chunk + 17'd1;
			expect_beat(it.payload_byte, remaining == 24'd0, 1'b0);
			if (remaining == 24'd0) begin
				msg_open = 1'b0;
				in_chunk = '0;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size = rcsf_pkg::CHUNK_SIZE_RST;
			open_csid  = '0;
			remaining  = '0;
			in_chunk   = '0;
			msg_open   = 1'b0;
			want_bytes.delete();
			bad = 0;
			mismatches <= 0;
			owed       <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (want_bytes.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %02h last %0b error %0b",
						$time, out_data.out_byte, out_data.last, out_data.error);
					bad++;
				end else begin
					want = want_bytes.pop_front();
					if (want.out_byte !== out_data.out_byte) begin
						$display("%0t: out_byte mismatch, expected %02h, actual %02h",
							$time, want.out_byte, out_data.out_byte);
						bad++;
					end
					if (want.last !== out_data.last) begin
						$display("%0t: last mismatch, expected %0b, actual %0b",
							$time, want.last, out_data.last);
						bad++;
					end
					if (want.error !== out_data.error) begin
						$display("%0t: error mismatch, expected %0b, actual %0b",
							$time, want.error, out_data.error);
						bad++;
					end
				end
			end
			if (in_valid && in_ready)
				frame_item(in_data);
			if (cfg_wen)
				chunk_size = cfg_wdata;
			mismatches <= bad;
			owed       <= want_bytes.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	rcsf_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready = 1'b0;
	rcsf_pkg::out_item_t out_data;
	logic                cfg_wen;
	logic [16:0]         cfg_wdata;

	int mismatches, owed;
	int snd_idle = 0;
	int rcv_idle = 0;
	int n_items, n_headers, n_payloads, n_strays, n_sizes;
	int msg_left;
	int spin;

	rtmp_chunk_stream_framer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	rcsf_stream_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.owed       (owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// unused fields carry random junk
	function automatic rcsf_pkg::in_item_t noise();
		rcsf_pkg::in_item_t it;
		it.op              = rcsf_pkg::OP_PAYLOAD;
		it.chunk_stream_id = 6'($urandom);
		it.time_stamp      = 24'($urandom);
		it.message_length  = 24'($urandom);
		it.message_type    = 8'($urandom);
		it.message_stream  = $urandom;
		it.payload_byte    = 8'($urandom);
		return it;
	endfunction

	task automatic send(input rcsf_pkg::in_item_t it);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		n_items++;
		if (it.op == rcsf_pkg::OP_HEADER) begin
			n_headers++;
			msg_left = int'(it.message_length);
		end else begin
			n_payloads++;
			if (msg_left == 0)
				n_strays++;
			else
				msg_left--;
		end
	endtask

	task automatic send_header(input logic [5:0] csid, input logic [23:0] ts,
			input logic [23:0] len, input logic [7:0] typ, input logic [31:0] sid);
		rcsf_pkg::in_item_t it;
		it = noise();
		it.op              = rcsf_pkg::OP_HEADER;
		it.chunk_stream_id = csid;
		it.time_stamp      = ts;
		it.message_length  = len;
		it.message_type    = typ;
		it.message_stream  = sid;
		send(it);
	endtask

	task automatic send_payload(input logic [7:0] b);
		rcsf_pkg::in_item_t it;
		it = noise();
		it.payload_byte = b;
		send(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (owed != 0);
	endtask

	task automatic set_size(input logic [16:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		n_sizes++;
	endtask

	task automatic random_message();
		int r, len, nsend;
		r = $urandom_range(99);
		if (r < 8)
			len = 0;
		else if (r < 80)
			len = $urandom_range(24, 1);
		else if (r < 90)
			len = $urandom_range(80, 25);
		else
			len = $urandom & 32'hFFFFFF;
		nsend = len;
		if (r >= 90)
			nsend = $urandom_range(6, 0);
		else if (len > 0 && $urandom_range(99) < 8)
			nsend = $urandom_range(len - 1, 0);
		send_header(6'($urandom), 24'($urandom), 24'(len), 8'($urandom), $urandom);
		repeat (nsend) send_payload(8'($urandom));
		if ($urandom_range(99) < 10)
			send_payload(8'($urandom));
		if ($urandom_range(99) < 5)
			drain();
	endtask

	task automatic random_phase(input int s_idle, input int r_idle,
			input logic [16:0] s0, input logic [16:0] s1, input logic [16:0] s2);
		logic [16:0] sizes [3];
		int stop;
		sizes    = '{s0, s1, s2};
		snd_idle = s_idle;
		rcv_idle = r_idle;
		foreach (sizes[k]) begin
			drain();
			set_size(sizes[k]);
			stop = n_items + 28;
			while (n_items < stop) random_message();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		n_items    = 0;
		n_headers  = 0;
		n_payloads = 0;
		n_strays   = 0;
		n_sizes    = 0;
		msg_left   = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle = 17;
		rcv_idle = 79;
		send_payload(8'h5A);
		send_header(6'd0, 24'd0, 24'd0, 8'd0, 32'd0);
		send_header(6'h3F, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 32'hFFFFFFFF);
		send_payload(8'hFF);
		send_payload(8'h00);
		send_header(6'h2A, 24'h123456, 24'd1, 8'h14, 32'h01020304);
		send_payload(8'hA5);
		send_payload(8'h3C);
		// chunk size moved while a message is open
		drain();
		set_size(17'd4);
		send_header(6'h05, 24'h000100, 24'd10, 8'h09, 32'd1);
		repeat (3) send_payload(8'($urandom));
		drain();
		set_size(17'd1);
		repeat (2) send_payload(8'($urandom));
		drain();
		set_size(17'd3);
		repeat (5) send_payload(8'($urandom));
		drain();
		set_size(17'd0);
		send_header(6'h3F, 24'd0, 24'd3, 8'h08, 32'd0);
		repeat (3) send_payload(8'($urandom));

		random_phase(17, 79, 17'd1, 17'd3, 17'd8);
		random_phase(79, 17, 17'd65536, 17'd2, 17'd5);
		random_phase(0, 0, 17'd7, 17'd65535, 17'd128);

		in_valid <= 1'b0;
		spin = 0;
		do begin
			@(posedge clk);
			spin++;
		end while (owed != 0 && spin < 20000);
		repeat (16) @(posedge clk);
		if (owed != 0)
			$display("%0t: %0d expected beats never arrived", $time, owed);
		$display("Covered %0d input beats: %0d headers, %0d payload bytes",
			n_items, n_headers, n_payloads);
		$display("(%0d with no message open), chunk size written %0d times over three stall mixes.",
			n_strays, n_sizes);
		if (mismatches == 0 && owed == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/rcsf_pkg.sv
sv/rcsf_frame.sv
sv/rcsf_serial.sv
sv/rtmp_chunk_stream_framer_top.sv
sv/rcsf_checker.sv
tb/sv/rcsf_stream_checker.sv
tb/sv/tb.sv
